### hw/rtl/sacp_pkg.sv
package sacp_pkg;

  localparam int unsigned WORD_COST = 100;

  typedef enum logic [2:0] {
    CFG_SET_BITS      = 3'd0,
    CFG_WAYS          = 3'd1,
    CFG_OFFSET_BITS   = 3'd2,
    CFG_WRITE_THROUGH = 3'd3,
    CFG_NO_ALLOC      = 3'd4,
    CFG_LRU           = 3'd5
  } cfg_reg_t;

  // per-way record kept in the line store
  typedef struct packed {
    logic [31:0] line;
    logic [31:0] fstamp;
    logic [31:0] astamp;
  } way_rec_t;

  // control from sequencer to the way store
  typedef struct packed {
    logic wr;
    logic set_valid;
    logic dirty_wr;
    logic dirty_val;
  } store_ctl_t;

endpackage

### hw/rtl/set_assoc_cache_policy_core.sv
// Per access the sequencer walks the ways of the set once through the single read port
// of the line store to search for the tag, then a second time to pick the victim (on a
// hit, to reload the hit way's record), then writes at most one entry. busy is high for
// that whole time; the result is registered on the outputs with done high for one cycle
// and cannot be held off. After reset a clearing pass over every entry of the line store
// keeps busy high; configuration writes are taken at any time.
module set_assoc_cache_policy_core
  import sacp_pkg::*;
#(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [31:0] address,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  output logic        done,
  output logic        is_hit,
  output logic        wrote_back,
  output logic [11:0] access_cost,
  output logic [39:0] total_cycles,
  output logic [31:0] load_count,
  output logic [31:0] store_count,
  output logic [31:0] load_hit_count,
  output logic [31:0] store_hit_count
);

  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W = $clog2(MAX_WAYS + 1);
  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int IDX_W = MAX_SET_BITS + WAY_W;
  localparam int SB_W = $clog2(MAX_SET_BITS + 1) + 1;
  localparam logic [39:0] MAX40 = '1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SEARCH, S_DECIDE, S_VICTIM, S_WRITE, S_DONE
  } state_t;

  state_t state;

  logic [3:0] set_bits;
  logic [3:0] ways_in_use;
  logic [2:0] offset_bits;
  logic       wt_mode, no_alloc_mode, lru_policy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits      <= '0;
      ways_in_use   <= 4'd1;
      offset_bits   <= 3'd2;
      wt_mode       <= 1'b0;
      no_alloc_mode <= 1'b0;
      lru_policy    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SET_BITS:      set_bits <= cfg_data;
        CFG_WAYS:          ways_in_use <= cfg_data;
        CFG_OFFSET_BITS:   offset_bits <= cfg_data[2:0];
        CFG_WRITE_THROUGH: wt_mode <= cfg_data[0];
        CFG_NO_ALLOC:      no_alloc_mode <= cfg_data[0];
        CFG_LRU:           lru_policy <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [SB_W-1:0]   sb;
  logic [WCNT_W-1:0] ways;
  logic [2:0]        ob;
  logic [3:0]        ob_m2;
  logic [11:0]       word_cost;
  always_comb begin
    sb = (32'(set_bits) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS) : SB_W'(set_bits);
    if (ways_in_use == 4'd0) ways = WCNT_W'(1);
    else if (32'(ways_in_use) > MAX_WAYS) ways = WCNT_W'(MAX_WAYS);
    else ways = WCNT_W'(ways_in_use);
    ob = (offset_bits < 3'd2) ? 3'd2 : ((offset_bits > 3'd6) ? 3'd6 : offset_bits);
    ob_m2 = 4'(ob) - 4'd2;
    word_cost = 12'(WORD_COST) << ob_m2;
  end

  // item registers
  logic              store;
  logic [31:0]       line;
  logic [SET_W-1:0]  set_q;
  logic [31:0]       stamp;
  logic [WCNT_W-1:0] wcnt;
  logic [1:0]        phase;
  logic              found, got_inv, fill, fill_dirty;
  logic [WAY_W-1:0]  hit_way, victim;
  logic [31:0]       best_key;
  logic [31:0]       hit_fstamp;
  logic              victim_dirty;
  logic [IDX_W-1:0]  clr_idx;
  logic [31:0]       addr_m;

  logic [31:0] access_counter;
  logic [39:0] cycle_total;
  logic [31:0] cnt [4];

  assign addr_m = address & 32'((64'd1 << ADDR_BITS) - 64'd1);

  way_rec_t   rd_rec, wr_rec;
  logic       rd_valid, rd_dirty;
  store_ctl_t ctl;
  logic [IDX_W-1:0] rd_idx, wr_idx;
  logic [WAY_W-1:0] rd_way;

  assign rd_way = wcnt[WAY_W-1:0];
  generate
    if (MAX_SET_BITS > 0) begin : g_idx
      assign rd_idx = {set_q[MAX_SET_BITS-1:0], rd_way};
      assign wr_idx = (state == S_CLEAR) ? clr_idx
                    : {set_q[MAX_SET_BITS-1:0], found ? hit_way : victim};
    end else begin : g_idx0
      assign rd_idx = rd_way;
      assign wr_idx = (state == S_CLEAR) ? clr_idx : (found ? hit_way : victim);
    end
  endgenerate

  always_comb begin
    ctl = '0;
    wr_rec.line = line;
    wr_rec.fstamp = found ? hit_fstamp : stamp;
    wr_rec.astamp = stamp;
    if (state == S_WRITE) begin
      if (found) begin
        // a hit rewrites the access stamp and dirty bit; keep the captured fill stamp
        ctl.wr = 1'b1;
        ctl.dirty_wr = 1'b1;
        ctl.dirty_val = victim_dirty;
      end else if (fill) begin
        ctl.wr = 1'b1;
        ctl.set_valid = 1'b1;
        ctl.dirty_val = fill_dirty;
      end
    end
  end

  sacp_way_store #(.IDX_W(IDX_W)) u_store (
    .clk, .rst,
    .clr_en  (state == S_CLEAR),
    .rd_idx, .wr_idx, .ctl, .wr_rec, .rd_rec, .rd_valid, .rd_dirty
  );

  // the shared compare unit: one way record against a key each cycle
  logic [31:0] key_cur;
  logic        tag_eq, key_lt;
  assign key_cur = lru_policy ? rd_rec.astamp : rd_rec.fstamp;
  assign tag_eq  = rd_rec.line == line;
  assign key_lt  = key_cur < best_key;

  logic [WAY_W-1:0] cur_way;
  assign cur_way = rd_way - WAY_W'(1);

  logic [12:0] cost_base;
  always_comb begin
    cost_base = '0;
    if (found) begin
      if (!store) cost_base = 13'd1;
      else if (wt_mode) cost_base = 13'd101;
      else if (!no_alloc_mode) cost_base = 13'd1;
    end else if (!store) cost_base = 13'(word_cost) + 13'd1;
    else if (!no_alloc_mode) cost_base = 13'(word_cost) + (wt_mode ? 13'd101 : 13'd1);
    else if (wt_mode) cost_base = 13'd100;
  end

  logic        wb_now;
  logic [12:0] cost_now;
  logic [40:0] tot_sum;
  assign wb_now   = fill && !wt_mode && victim_dirty;
  assign cost_now = cost_base + (wb_now ? 13'(word_cost) : 13'd0);
  assign tot_sum  = {1'b0, cycle_total} + 41'(cost_now);

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      done <= 1'b0;
      access_counter <= '0;
      cycle_total <= '0;
      for (int i = 0; i < 4; i++) cnt[i] <= '0;
      total_cycles <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IDX_W'(1);
          if (&clr_idx) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            store <= action;
            line <= addr_m & ~((32'd1 << ob) - 32'd1);
            set_q <= SET_W'((addr_m >> ob) & ((32'd1 << sb) - 32'd1));
            access_counter <= access_counter + 32'd1;
            stamp <= access_counter + 32'd1;
            wcnt <= '0;
            phase <= 2'd0;
            found <= 1'b0;
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          // phase 0 issues read of way 0; later cycles check the way read before
          if (phase != 2'd0 && !found && rd_valid && tag_eq) begin
            found <= 1'b1;
            hit_way <= cur_way;
          end
          phase <= 2'd1;
          if (wcnt == ways) begin
            state <= S_DECIDE;
          end else begin
            wcnt <= wcnt + WCNT_W'(1);
          end
        end
        S_DECIDE: begin
          cnt[store ? 1 : 0] <= (&cnt[store ? 1 : 0]) ? cnt[store ? 1 : 0]
                                                      : cnt[store ? 1 : 0] + 32'd1;
          if (found) begin
            cnt[store ? 3 : 2] <= (&cnt[store ? 3 : 2]) ? cnt[store ? 3 : 2]
                                                        : cnt[store ? 3 : 2] + 32'd1;
          end
          fill <= !found && (!store || !no_alloc_mode);
          fill_dirty <= store && !wt_mode;
          got_inv <= 1'b0;
          victim <= '0;
          victim_dirty <= 1'b0;
          wcnt <= '0;
          phase <= 2'd0;
          state <= S_VICTIM;
        end
        S_VICTIM: begin
          // on a hit this walk just reloads the hit way's flags and record
          if (phase != 2'd0) begin
            if (found) begin
              if (cur_way == hit_way) begin
                victim_dirty <= rd_dirty || (store && !wt_mode && !no_alloc_mode);
                hit_fstamp <= rd_rec.fstamp;
              end
            end else if (!got_inv) begin
              if (!rd_valid) begin
                got_inv <= 1'b1;
                victim <= cur_way;
                victim_dirty <= 1'b0;
              end else if (phase == 2'd1 || key_lt) begin
                victim <= cur_way;
                best_key <= key_cur;
                victim_dirty <= rd_dirty;
              end
            end
            phase <= 2'd2;
          end else begin
            phase <= 2'd1;
          end
          if (wcnt == ways) begin
            wcnt <= WCNT_W'(found ? hit_way : victim);
            state <= S_WRITE;
          end else begin
            wcnt <= wcnt + WCNT_W'(1);
          end
        end
        S_WRITE: begin
          state <= S_DONE;
        end
        S_DONE: begin
          is_hit <= found;
          wrote_back <= wb_now;
          access_cost <= cost_now[11:0];
          cycle_total <= tot_sum[40] ? MAX40 : tot_sum[39:0];
          total_cycles <= tot_sum[40] ? MAX40 : tot_sum[39:0];
          load_count <= cnt[0];
          store_count <= cnt[1];
          load_hit_count <= cnt[2];
          store_hit_count <= cnt[3];
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("done outside idle");
  a_start_search: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> state == S_SEARCH) else $error("start lost");
  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    done && $past(state) == S_DONE |-> total_cycles >= $past(cycle_total))
    else $error("total decreased");
`endif

endmodule

### hw/rtl/sacp_way_store.sv
module sacp_way_store
  import sacp_pkg::*;
#(
  parameter int IDX_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clr_en,
  input  logic [IDX_W-1:0] rd_idx,
  input  logic [IDX_W-1:0] wr_idx,
  input  store_ctl_t       ctl,
  input  way_rec_t         wr_rec,
  output way_rec_t         rd_rec,
  output logic             rd_valid,
  output logic             rd_dirty
);

  localparam int DEPTH = 1 << IDX_W;

  way_rec_t   mem [DEPTH];
  logic [1:0] flags [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_idx] <= wr_rec;
    end
    rd_rec <= mem[rd_idx];
  end

  // flags: {valid, dirty}; cleared by a sweep after reset
  always_ff @(posedge clk) begin
    if (clr_en) begin
      flags[wr_idx] <= 2'b00;
    end else if (ctl.set_valid || ctl.dirty_wr) begin
      flags[wr_idx] <= {1'b1, ctl.dirty_val};
    end
    if (rst) begin
      rd_valid <= 1'b0;
      rd_dirty <= 1'b0;
    end else begin
      rd_valid <= flags[rd_idx][1];
      rd_dirty <= flags[rd_idx][0];
    end
  end

endmodule

### dv/set_assoc_cache_policy_core_tb.sv
module set_assoc_cache_policy_core_tb;
  import sacp_pkg::*;

  localparam int SET_MAX  = 8;
  localparam int WAY_MAX  = 8;
  localparam int ENTRIES  = WAY_MAX << SET_MAX;
  localparam logic [2:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [2:0] CFG_UNUSED_HI = 3'd7;
  localparam bit OP_LOAD  = 1'b0;
  localparam bit OP_STORE = 1'b1;

  typedef struct {
    bit          hit;
    bit          wb;
    logic [11:0] cost;
    logic [39:0] total;
    logic [31:0] loads;
    logic [31:0] stores;
    logic [31:0] ld_hit_cnt;
    logic [31:0] st_hit_cnt;
  } access_res_t;

  // directed row: either a register write or an access with optional typed result
  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [3:0]  data;
    bit          act;
    logic [31:0] addr;
    bit          typed;
    bit          hit;
    bit          wb;
    int          cost;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        action = 1'b0;
  logic [31:0] address = '0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;
  logic        busy, cfg_ready, done, is_hit, wrote_back;
  logic [11:0] access_cost;
  logic [39:0] total_cycles;
  logic [31:0] load_count, store_count, load_hit_count, store_hit_count;

  set_assoc_cache_policy_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action), .address(address),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .is_hit(is_hit), .wrote_back(wrote_back),
    .access_cost(access_cost), .total_cycles(total_cycles), .load_count(load_count),
    .store_count(store_count), .load_hit_count(load_hit_count),
    .store_hit_count(store_hit_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow cache state
  bit          sh_valid [ENTRIES];
  bit          sh_dirty [ENTRIES];
  logic [31:0] sh_line  [ENTRIES];
  logic [31:0] sh_fill  [ENTRIES];
  logic [31:0] sh_touch [ENTRIES];
  logic [31:0] sh_counter;
  logic [39:0] sh_total;
  logic [31:0] sh_ops [4];
  logic [3:0]  r_set_bits, r_ways;
  logic [2:0]  r_offset;
  bit          r_wt, r_noalloc, r_lru;

  access_res_t pending_results[$];
  int          errors = 0;
  bit          no_idle = 1'b0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [31:0] bump(input logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  function automatic void apply_cfg(input logic [2:0] idx, input logic [3:0] d);
    case (idx)
      CFG_SET_BITS:      r_set_bits = d;
      CFG_WAYS:          r_ways = d;
      CFG_OFFSET_BITS:   r_offset = d[2:0];
      CFG_WRITE_THROUGH: r_wt = d[0];
      CFG_NO_ALLOC:      r_noalloc = d[0];
      CFG_LRU:           r_lru = d[0];
      default: ;
    endcase
  endfunction

  function automatic access_res_t predict_access(input bit st, input logic [31:0] a);
    access_res_t r;
    int sb, ways, ob, words, set_i, base, found, victim, e, cost;
    logic [31:0] line, stamp;
    logic [40:0] sum;
    bit fill, fill_dirty;
    sb = (r_set_bits > SET_MAX) ? SET_MAX : r_set_bits;
    ways = (r_ways == 0) ? 1 : ((r_ways > WAY_MAX) ? WAY_MAX : r_ways);
    ob = (r_offset < 2) ? 2 : ((r_offset > 6) ? 6 : r_offset);
    words = 1 << (ob - 2);
    set_i = (a >> ob) & ((1 << sb) - 1);
    line = a & ~((32'd1 << ob) - 1);
    base = set_i * WAY_MAX;
    r = '{default: '0};
    cost = 0;
    fill = 0;
    fill_dirty = 0;
    found = -1;
    sh_counter = sh_counter + 32'd1;
    stamp = sh_counter;
    for (int w = 0; w < ways; w++)
      if (found < 0 && sh_valid[base + w] && sh_line[base + w] == line) found = w;
    sh_ops[st ? 1 : 0] = bump(sh_ops[st ? 1 : 0]);
    if (found >= 0) begin
      e = base + found;
      r.hit = 1;
      sh_ops[st ? 3 : 2] = bump(sh_ops[st ? 3 : 2]);
      sh_touch[e] = stamp;
      if (!st) cost = 1;
      else if (r_wt) cost = 101;
      else if (!r_noalloc) begin
        cost = 1;
        sh_dirty[e] = 1;
      end
    end else if (!st) begin
      cost = 100 * words + 1;
      fill = 1;
    end else if (!r_noalloc) begin
      fill = 1;
      if (r_wt) cost = 100 * words + 101;
      else begin
        cost = 100 * words + 1;
        fill_dirty = 1;
      end
    end else if (r_wt) cost = 100;
    if (fill) begin
      victim = -1;
      for (int w = 0; w < ways; w++)
        if (victim < 0 && !sh_valid[base + w]) victim = w;
      if (victim < 0) begin
        victim = 0;
        for (int w = 1; w < ways; w++)
          if (r_lru ? (sh_touch[base + w] < sh_touch[base + victim])
                    : (sh_fill[base + w] < sh_fill[base + victim])) victim = w;
      end
      e = base + victim;
      if (!r_wt && sh_valid[e] && sh_dirty[e]) begin
        cost = cost + 100 * words;
        r.wb = 1;
      end
      sh_valid[e] = 1;
      sh_dirty[e] = fill_dirty;
      sh_line[e] = line;
      sh_fill[e] = stamp;
      sh_touch[e] = stamp;
    end
    r.cost = 12'(cost);
    sum = {1'b0, sh_total} + 41'(cost);
    sh_total = sum[40] ? 40'hFF_FFFF_FFFF : sum[39:0];
    r.total = sh_total;
    r.loads = sh_ops[0];
    r.stores = sh_ops[1];
    r.ld_hit_cnt = sh_ops[2];
    r.st_hit_cnt = sh_ops[3];
    return r;
  endfunction

  // issue one access; start stays high afterwards so back-to-back items need no toggle
  task automatic issue_access(input bit st, input logic [31:0] a, output access_res_t r);
    if (!no_idle && $urandom_range(0, 99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    action <= st;
    address <= a;
    do @(posedge clk); while (busy);
    r = predict_access(st, a);
    pending_results.push_back(r);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [3:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_cfg(idx, d);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report("unexpected item", 1, 0);
      end else begin
        access_res_t x;
        x = pending_results.pop_front();
        if (is_hit !== x.hit) report("is_hit", is_hit, x.hit);
        if (wrote_back !== x.wb) report("wrote_back", wrote_back, x.wb);
        if (access_cost !== x.cost) report("access_cost", access_cost, x.cost);
        if (total_cycles !== x.total) report("total_cycles", total_cycles, x.total);
        if (load_count !== x.loads) report("load_count", load_count, x.loads);
        if (store_count !== x.stores) report("store_count", store_count, x.stores);
        if (load_hit_count !== x.ld_hit_cnt)
          report("load_hit_count", load_hit_count, x.ld_hit_cnt);
        if (store_hit_count !== x.st_hit_cnt)
          report("store_hit_count", store_hit_count, x.st_hit_cnt);
      end
    end
  end

  initial begin
    #8000000;
    $display("FAIL set_assoc_cache_policy_core");
    $finish;
  end

  function automatic row_t acc(input bit st, input logic [31:0] a);
    return '{0, 3'd0, 4'd0, st, a, 0, 0, 0, 0};
  endfunction

  function automatic row_t acc_typed(input bit st, input logic [31:0] a, input bit h,
                                     input bit w, input int c);
    return '{0, 3'd0, 4'd0, st, a, 1, h, w, c};
  endfunction

  function automatic row_t cfg(input logic [2:0] idx, input logic [3:0] d);
    return '{1, idx, d, 0, '0, 0, 0, 0, 0};
  endfunction

  initial begin
    row_t        rows[$];
    access_res_t r;
    logic [31:0] hi_base, a;
    int          sb, ways, ob, n_phase;
    bit          st;

    sh_counter = '0;
    sh_total = '0;
    foreach (sh_ops[i]) sh_ops[i] = '0;
    foreach (sh_valid[i]) begin
      sh_valid[i] = 0;
      sh_dirty[i] = 0;
    end
    r_set_bits = 0; r_ways = 1; r_offset = 2; r_wt = 0; r_noalloc = 0; r_lru = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // one set, one way, one-word blocks after reset
    rows = '{
      acc_typed(OP_LOAD,  32'h0000_0000, 0, 0, 101),
      acc_typed(OP_LOAD,  32'h0000_0003, 1, 0, 1),
      acc_typed(OP_STORE, 32'h0000_0000, 1, 0, 1),
      acc_typed(OP_LOAD,  32'hFFFF_FFFF, 0, 1, 201),
      acc_typed(OP_STORE, 32'hFFFF_FFFC, 1, 0, 1),
      acc_typed(OP_STORE, 32'h0000_0004, 0, 1, 201),
      cfg(CFG_NO_ALLOC, 4'd1),
      acc_typed(OP_STORE, 32'h0000_0004, 1, 0, 0),
      acc_typed(OP_STORE, 32'h1234_5678, 0, 0, 0),
      cfg(CFG_WRITE_THROUGH, 4'd1),
      acc_typed(OP_STORE, 32'h1234_5678, 0, 0, 100),
      acc_typed(OP_STORE, 32'h0000_0004, 1, 0, 101),
      cfg(CFG_NO_ALLOC, 4'd0),
      acc_typed(OP_STORE, 32'h8000_0000, 0, 0, 201),
      // out-of-range geometry saturates; unused indexes do nothing
      cfg(CFG_SET_BITS, 4'd15), cfg(CFG_WAYS, 4'd15), cfg(CFG_OFFSET_BITS, 4'd7),
      cfg(CFG_UNUSED_LO, 4'd15), cfg(CFG_UNUSED_HI, 4'd0), cfg(CFG_WRITE_THROUGH, 4'd0),
      acc(OP_LOAD, 32'h0000_0040), acc(OP_STORE, 32'h0000_0041), acc(OP_LOAD, 32'h0000_4040),
      cfg(CFG_LRU, 4'd1), cfg(CFG_WAYS, 4'd0), cfg(CFG_OFFSET_BITS, 4'd0),
      cfg(CFG_SET_BITS, 4'd0),
      acc(OP_LOAD, 32'h0000_0040), acc(OP_STORE, 32'h0000_0100), acc(OP_LOAD, 32'h0000_0040),
      cfg(CFG_WAYS, 4'd8), cfg(CFG_SET_BITS, 4'd8), cfg(CFG_OFFSET_BITS, 4'd6),
      acc(OP_STORE, 32'hFFFF_FFC0), acc(OP_LOAD, 32'h0000_0000), acc(OP_LOAD, 32'hFFFF_FFFF)
    };
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        if (i == 0 || !rows[i-1].is_cfg) drain();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        issue_access(rows[i].act, rows[i].addr, r);
        if (rows[i].typed && (r.hit != rows[i].hit || r.wb != rows[i].wb ||
                              r.cost != rows[i].cost))
          report("directed row cost", r.cost, rows[i].cost);
      end
    end

    // random phases: each a new setting, most accesses hitting a few crowded sets
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      if (ph == 0) begin
        write_reg(CFG_SET_BITS, 4'd0); write_reg(CFG_WAYS, 4'd1);
        write_reg(CFG_OFFSET_BITS, 4'd2);
      end else if (ph == 1) begin
        write_reg(CFG_SET_BITS, 4'd8); write_reg(CFG_WAYS, 4'd8);
        write_reg(CFG_OFFSET_BITS, 4'd6);
      end else begin
        write_reg(CFG_SET_BITS, 4'($urandom_range(0, 15)));
        write_reg(CFG_WAYS, 4'($urandom_range(0, 15)));
        write_reg(CFG_OFFSET_BITS, 4'($urandom_range(0, 7)));
      end
      write_reg(CFG_WRITE_THROUGH, 4'($urandom_range(0, 1)));
      write_reg(CFG_NO_ALLOC, 4'($urandom_range(0, 1)));
      write_reg(CFG_LRU, 4'($urandom_range(0, 1)));
      no_idle = (ph == 3);
      sb = (r_set_bits > SET_MAX) ? SET_MAX : r_set_bits;
      ways = (r_ways == 0) ? 1 : ((r_ways > WAY_MAX) ? WAY_MAX : r_ways);
      ob = (r_offset < 2) ? 2 : ((r_offset > 6) ? 6 : r_offset);
      hi_base = $urandom();
      n_phase = 70;
      for (int k = 0; k < n_phase; k++) begin
        if (ph == 5 && k == 35) begin
          start <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
        st = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 80) begin
          a = ((hi_base + $urandom_range(0, 2 * ways + 1)) << (ob + sb))
              | ($urandom_range(0, 2) << ob) | $urandom_range(0, (1 << ob) - 1);
        end else begin
          a = $urandom();
        end
        issue_access(st, a, r);
      end
    end
    no_idle = 1'b0;

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("PASS set_assoc_cache_policy_core");
    end else begin
      $display("FAIL set_assoc_cache_policy_core");
    end
    $finish;
  end

endmodule
